// ===== sv/tiff_colormap_rescaler_macros.svh =====
// Assertion macros shared by the palette rescaler RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TIFF_COLORMAP_RESCALER_MACROS_SVH
`define TIFF_COLORMAP_RESCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcr: next-cycle check failed");

`endif

// ===== sv/tcr_pkg.sv =====
// Shared constants, codes and types of the palette rescaler.
// No dependencies; imported by tcr_divider, tiff_colormap_rescaler and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int COMP_W      = 16;
	localparam int ENTRY_W     = 3 * COMP_W;
	localparam int FACT_W      = 9;
	localparam int REM_W       = FACT_W + 1;
	localparam int DIV_STEPS   = COMP_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int LANES       = 3;

	// Item operation codes.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_FORCED  = 2'd0;
	localparam logic [1:0] REG_DEFAULT = 2'd1;
	localparam logic [1:0] REG_NODATA_EN  = 2'd2;
	localparam logic [1:0] REG_NODATA_IDX = 2'd3;

	localparam logic [FACT_W-1:0] FACT_ONE      = 9'd1;
	localparam logic [FACT_W-1:0] FACT_256      = 9'd256;
	localparam logic [FACT_W-1:0] FACT_DEFAULT  = 9'd257;
	localparam logic [7:0]        ALPHA_OPAQUE  = 8'd255;
	localparam logic [7:0]        ALPHA_CLEAR   = 8'd0;

	typedef logic [COMP_W-1:0] comp_t;
	typedef logic [LANES-1:0][COMP_W-1:0] lanes_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== sv/tcr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the palette store.
`timescale 1ns / 1ps
`default_nettype none

module tcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/tcr_divider.sv =====
// Three-lane restoring divider: one quotient bit per lane each cycle.
// Depends on tcr_pkg; all lanes share one divisor.
`timescale 1ns / 1ps
`default_nettype none

module tcr_divider import tcr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FACT_W-1:0] divisor,
	input  wire lanes_t            dividend,
	output lanes_t                 quotient,
	output div_stat_t              stat
);

	logic [REM_W-1:0]  rem_q [LANES];
	lanes_t            quo_q;
	logic [FACT_W-1:0] divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0] rem_sh  [LANES];
	logic [REM_W-1:0] rem_sub [LANES];
	logic [LANES-1:0] fits;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_sh[l]  = {rem_q[l][REM_W-2:0], quo_q[l][COMP_W-1]};
			fits[l]    = rem_sh[l] >= {1'b0, divisor_q};
			rem_sub[l] = rem_sh[l] - {1'b0, divisor_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The quotient register doubles as the dividend shifter.
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			quo_q     <= dividend;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (busy_q) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= fits[l] ? rem_sub[l] : rem_sh[l];
				quo_q[l] <= {quo_q[l][COMP_W-2:0], fits[l]};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== sv/tiff_colormap_rescaler.sv =====
// Top level of the palette rescaler: flags, scale choice, control and output register.
// Depends on tcr_pkg, tcr_ram, tcr_divider and tiff_colormap_rescaler_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  in       | in_valid / in_ready    | op, red_in, green_in, blue_in, read_index
//  out      | out_valid / out_ready  | entry_index, red_out, green_out, blue_out,
//           |                        | alpha_out, multiplier, entry_valid
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Load, clear and unused items leave the block idle, so input stays ready after them. A read
// item passes S_MEM, which starts the divider with the registered RAM data, then S_DIV, where
// all three components are divided in parallel, and its quotients move to the output register
// once that is free. No new item is accepted until then.
// Reset clears the count and flags at once; unwritten RAM entries are never returned.
// A stalled output holds the block only when a second read finishes dividing before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "tiff_colormap_rescaler_macros.svh"

module tiff_colormap_rescaler import tcr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        op,
	input  wire logic [COMP_W-1:0] red_in,
	input  wire logic [COMP_W-1:0] green_in,
	input  wire logic [COMP_W-1:0] blue_in,
	input  wire logic [7:0]        read_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             entry_index,
	output logic [COMP_W-1:0]      red_out,
	output logic [COMP_W-1:0]      green_out,
	output logic [COMP_W-1:0]      blue_out,
	output logic [7:0]             alpha_out,
	output logic [FACT_W-1:0]      multiplier,
	output logic                   entry_valid,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [FACT_W-1:0] cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MEM  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0] state_q;

	logic [FACT_W-1:0] forced_q;
	logic [FACT_W-1:0] default_q;
	logic              nodata_en_q;
	logic [7:0]        nodata_idx_q;

	logic [CNT_W-1:0] entry_count_q;
	logic             seen_nonzero_q;
	logic             all_mult_256_q;
	logic             all_mult_257_q;
	comp_t            max_component_q;

	logic [7:0]        idx_s1;
	logic              valid_s1;
	logic [7:0]        alpha_s1;
	logic [FACT_W-1:0] fact_s1;

	logic              out_valid_q;
	logic [7:0]        out_index_q;
	lanes_t            out_comp_q;
	logic [7:0]        out_alpha_q;
	logic [FACT_W-1:0] out_fact_q;
	logic              out_entry_valid_q;

	logic              in_fire;
	logic              load_fire;
	logic              read_fire;
	logic              clear_fire;
	logic              not_full;
	logic [ENTRY_W-1:0] rdata;
	lanes_t            quotient;
	div_stat_t         div_stat;
	logic              finish;
	logic              out_free;

	comp_t             max_rg;
	comp_t             max_rgb;
	logic [FACT_W-1:0] fact;
	logic              idx_valid;

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_fire    = in_valid && in_ready;
	assign not_full   = 32'(entry_count_q) < MAX_ENTRIES;
	assign load_fire  = in_fire && (op == OP_LOAD) && not_full;
	assign read_fire  = in_fire && (op == OP_READ);
	assign clear_fire = in_fire && (op == OP_CLEAR);

	tcr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (load_fire),
		.waddr(ADDR_W'(entry_count_q)),
		.wdata({red_in, green_in, blue_in}),
		.raddr(ADDR_W'(read_index)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forced_q     <= '0;
			default_q    <= FACT_DEFAULT;
			nodata_en_q  <= 1'b0;
			nodata_idx_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FORCED:     forced_q     <= cfg_data;
				REG_DEFAULT:    default_q    <= cfg_data;
				REG_NODATA_EN:  nodata_en_q  <= cfg_data[0];
				REG_NODATA_IDX: nodata_idx_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		max_rg  = (red_in > green_in) ? red_in : green_in;
		max_rgb = (max_rg > blue_in) ? max_rg : blue_in;
	end

	// A component is a multiple of 257 exactly when its two bytes are equal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			seen_nonzero_q  <= 1'b0;
			all_mult_256_q  <= 1'b1;
			all_mult_257_q  <= 1'b1;
			max_component_q <= '0;
		end else if (clear_fire) begin
			entry_count_q   <= '0;
			seen_nonzero_q  <= 1'b0;
			all_mult_256_q  <= 1'b1;
			all_mult_257_q  <= 1'b1;
			max_component_q <= '0;
		end else if (load_fire) begin
			entry_count_q <= entry_count_q + 1'b1;
			if ((red_in | green_in | blue_in) != '0) begin
				seen_nonzero_q <= 1'b1;
			end
			if ((red_in[7:0] | green_in[7:0] | blue_in[7:0]) != 8'd0) begin
				all_mult_256_q <= 1'b0;
			end
			if ((red_in[15:8] != red_in[7:0]) || (green_in[15:8] != green_in[7:0])
					|| (blue_in[15:8] != blue_in[7:0])) begin
				all_mult_257_q <= 1'b0;
			end
			if (max_rgb > max_component_q) begin
				max_component_q <= max_rgb;
			end
		end
	end

	always_comb begin
		if (forced_q != '0) begin
			fact = forced_q;
		end else if (max_component_q != '0 && max_component_q < comp_t'(256)) begin
			fact = FACT_ONE;
		end else if (seen_nonzero_q && all_mult_256_q) begin
			fact = FACT_256;
		end else if (default_q != '0) begin
			fact = default_q;
		end else begin
			fact = FACT_ONE;
		end
	end

	assign idx_valid = (32'(read_index) < 32'(entry_count_q)) && (32'(read_index) < MAX_ENTRIES);

	always_ff @(posedge clk) begin
		if (read_fire) begin
			idx_s1   <= read_index;
			valid_s1 <= idx_valid;
			fact_s1  <= fact;
			alpha_s1 <= (nodata_en_q && nodata_idx_q == read_index) ? ALPHA_CLEAR
				: ALPHA_OPAQUE;
		end
	end

	tcr_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_MEM),
		.divisor (fact_s1),
		.dividend({rdata[ENTRY_W-1 -: COMP_W], rdata[2*COMP_W-1 -: COMP_W],
			rdata[COMP_W-1:0]}),
		.quotient(quotient),
		.stat    (div_stat)
	);

	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_DIV) && div_stat.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (read_fire) begin
						state_q <= S_MEM;
					end
				end
				S_MEM: state_q <= S_DIV;
				S_DIV: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An index beyond the count returns zeros in the data fields.
	always_ff @(posedge clk) begin
		if (finish) begin
			out_index_q       <= idx_s1;
			out_fact_q        <= fact_s1;
			out_entry_valid_q <= valid_s1;
			out_comp_q        <= valid_s1 ? quotient : '0;
			out_alpha_q       <= valid_s1 ? alpha_s1 : ALPHA_CLEAR;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_index = out_index_q;
	assign red_out     = out_comp_q[2];
	assign green_out   = out_comp_q[1];
	assign blue_out    = out_comp_q[0];
	assign alpha_out   = out_alpha_q;
	assign multiplier  = out_fact_q;
	assign entry_valid = out_entry_valid_q;

	// No nonzero 16-bit value is a multiple of both 256 and 257.
	`TCR_ASSERT_NOW(a_flags_exclusive, seen_nonzero_q, !(all_mult_256_q && all_mult_257_q))
	`TCR_ASSERT_NOW(a_count_bound, 1'b1, 32'(entry_count_q) <= MAX_ENTRIES)
	`TCR_ASSERT_NEXT(a_read_starts_div, read_fire, state_q == S_MEM && !in_ready)
	`TCR_ASSERT_NEXT(a_finish_loads_out, finish, out_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the palette rescaler: random and directed load, read and clear items.
// Depends on tcr_pkg and tiff_colormap_rescaler; a scoreboard class predicts every read result.
`timescale 1ns / 1ps

import tcr_pkg::*;

typedef struct packed {
	logic [7:0]        idx;
	comp_t             red;
	comp_t             green;
	comp_t             blue;
	logic [7:0]        alpha;
	logic [FACT_W-1:0] mult;
	logic              vld;
} read_result_t;

class palette_checker;
	logic [ENTRY_W-1:0] entries [MAX_ENTRIES];
	int                 count;
	int                 high_water;
	bit                 any_nonzero;
	bit                 all_256;
	comp_t              peak;
	logic [FACT_W-1:0]  forced_div;
	logic [FACT_W-1:0]  default_div;
	bit                 nodata_on;
	logic [7:0]         nodata_at;
	read_result_t       scaled_reads [$];
	int                 mismatches;

	function new();
		count = 0;
		high_water = 0;
		any_nonzero = 0;
		all_256 = 1;
		peak = '0;
		forced_div = '0;
		default_div = FACT_DEFAULT;
		nodata_on = 0;
		nodata_at = '0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [FACT_W-1:0] data);
		case (idx)
			REG_FORCED:     forced_div = data;
			REG_DEFAULT:    default_div = data;
			REG_NODATA_EN:  nodata_on = data[0];
			REG_NODATA_IDX: nodata_at = data[7:0];
			default: ;
		endcase
	endfunction

	function void absorb(comp_t c);
		if (c != 0) any_nonzero = 1;
		if (c[7:0] != 0) all_256 = 0;
		if (c > peak) peak = c;
	endfunction

	function logic [FACT_W-1:0] scale_factor();
		if (forced_div != 0) return forced_div;
		if (peak != 0 && peak < 256) return FACT_ONE;
		if (any_nonzero && all_256) return FACT_256;
		return (default_div != 0) ? default_div : FACT_ONE;
	endfunction

	function void note_item(logic [1:0] kind, comp_t r, comp_t g, comp_t b, logic [7:0] idx);
		read_result_t      res;
		logic [FACT_W-1:0] div;
		comp_t             sr, sg, sb;
		case (kind)
			OP_LOAD: begin
				// A full palette drops the item without touching the flags.
				if (count < MAX_ENTRIES) begin
					entries[count] = {r, g, b};
					count++;
					if (count > high_water) high_water = count;
					absorb(r);
					absorb(g);
					absorb(b);
				end
			end
			OP_CLEAR: begin
				count = 0;
				any_nonzero = 0;
				all_256 = 1;
				peak = '0;
			end
			OP_READ: begin
				div = scale_factor();
				res.idx = idx;
				res.mult = div;
				if (idx < count) begin
					{sr, sg, sb} = entries[idx];
					res.red = comp_t'(sr / div);
					res.green = comp_t'(sg / div);
					res.blue = comp_t'(sb / div);
					res.alpha = (nodata_on && nodata_at == idx) ? ALPHA_CLEAR : ALPHA_OPAQUE;
					res.vld = 1'b1;
				end else begin
					res.red = '0;
					res.green = '0;
					res.blue = '0;
					res.alpha = ALPHA_CLEAR;
					res.vld = 1'b0;
				end
				scaled_reads.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function void compare_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		end
	endfunction

	function void check_read(read_result_t got);
		read_result_t want;
		if (scaled_reads.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result for index %0d arrived with no read outstanding", got.idx);
			return;
		end
		want = scaled_reads.pop_front();
		compare_field("entry_index", want.idx, got.idx);
		compare_field("red_out", want.red, got.red);
		compare_field("green_out", want.green, got.green);
		compare_field("blue_out", want.blue, got.blue);
		compare_field("alpha_out", want.alpha, got.alpha);
		compare_field("multiplier", want.mult, got.mult);
		compare_field("entry_valid", want.vld, got.vld);
	endfunction

	function int pending();
		return scaled_reads.size();
	endfunction
endclass

module tb;
	localparam int LIMIT = 400000;
	localparam int SETTLE = 24;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {FL_SMALL, FL_M256, FL_M257, FL_EXTREME, FL_ANY} flavor_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        op = OP_LOAD;
	comp_t             red_in = '0;
	comp_t             green_in = '0;
	comp_t             blue_in = '0;
	logic [7:0]        read_index = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        entry_index;
	comp_t             red_out;
	comp_t             green_out;
	comp_t             blue_out;
	logic [7:0]        alpha_out;
	logic [FACT_W-1:0] multiplier;
	logic              entry_valid;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = REG_FORCED;
	logic [FACT_W-1:0] cfg_data = '0;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	palette_checker sb;

	tiff_colormap_rescaler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_index(entry_index), .red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .alpha_out(alpha_out), .multiplier(multiplier),
		.entry_valid(entry_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic comp_t pick_component(flavor_t f);
		if ($urandom_range(0, 39) == 0) f = FL_ANY;
		case (f)
			FL_SMALL:   return ($urandom_range(0, 9) == 0) ? comp_t'(0) : comp_t'($urandom_range(1, 255));
			FL_M256:    return comp_t'($urandom_range(0, 255) << 8);
			FL_M257:    return comp_t'($urandom_range(0, 255) * 257);
			FL_EXTREME: begin
				case ($urandom_range(0, 8))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'h00FF;
					3: return 16'h0100;
					4: return 16'h0101;
					5: return 16'h7FFF;
					6: return 16'h8000;
					7: return 16'hFF00;
					default: return 16'hFFFF;
				endcase
			end
			default:    return comp_t'($urandom);
		endcase
	endfunction

	// Out-of-range reads only go to entries written at some point since reset.
	function automatic int pick_index();
		if (sb.high_water > sb.count && (sb.count == 0 || $urandom_range(0, 6) == 0))
			return $urandom_range(sb.count, sb.high_water - 1);
		if (sb.count == 0) return -1;
		return $urandom_range(0, sb.count - 1);
	endfunction

	task automatic idle_in(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	task automatic issue(logic [1:0] kind, comp_t r, comp_t g, comp_t b, logic [7:0] idx);
		idle_in(gap_len());
		@(negedge clk);
		op = kind;
		red_in = r;
		green_in = g;
		blue_in = b;
		read_index = idx;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(kind, r, g, b, idx);
	endtask

	task automatic load_entry(flavor_t f);
		issue(OP_LOAD, pick_component(f), pick_component(f), pick_component(f),
			8'($urandom));
	endtask

	task automatic read_one();
		int i;
		i = pick_index();
		if (i < 0)
			load_entry(FL_ANY);
		else
			issue(OP_READ, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom), 8'(i));
	endtask

	task automatic clear_palette();
		issue(OP_CLEAR, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom), 8'($urandom));
	endtask

	task automatic noise_item();
		case ($urandom_range(0, 3))
			0: load_entry(FL_ANY);
			1: read_one();
			2: clear_palette();
			default: issue(OP_UNUSED, comp_t'($urandom), comp_t'($urandom),
				comp_t'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic quiet_in();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [FACT_W-1:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic program_phase(int p);
		logic [FACT_W-1:0] f, d;
		logic              e;
		logic [7:0]        n;
		case (p)
			1: begin f = '0; d = FACT_DEFAULT; e = 1'b1; n = 8'd255; end
			2: begin f = '0; d = '0; e = 1'b1; n = 8'd0; end
			3: begin f = FACT_DEFAULT; d = FACT_ONE; e = 1'b0; n = 8'($urandom); end
			4: begin f = 9'h1FF; d = FACT_DEFAULT; e = 1'b1; n = 8'($urandom_range(0, 15)); end
			5: begin f = FACT_ONE; d = FACT_256; e = 1'b0; n = 8'($urandom); end
			6: begin
				f = '0;
				d = 9'($urandom_range(258, 511));
				e = 1'b1;
				n = 8'($urandom_range(0, 7));
			end
			7: begin f = FACT_256; d = FACT_ONE; e = 1'b1; n = 8'($urandom_range(0, 15)); end
			default: begin
				f = $urandom_range(0, 1) ? 9'($urandom_range(1, 511)) : '0;
				d = 9'($urandom_range(0, 511));
				e = 1'($urandom);
				n = 8'($urandom_range(0, 31));
			end
		endcase
		write_reg(REG_FORCED, f);
		write_reg(REG_DEFAULT, d);
		write_reg(REG_NODATA_EN, {8'd0, e});
		write_reg(REG_NODATA_IDX, {1'b0, n});
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers may only change with the block idle, so drain and let it settle first.
	task automatic settle();
		quiet_in();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_directed();
		issue(OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
		issue(OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
		issue(OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
		issue(OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'd1);
		clear_palette();
		// Index 1 holds stale data but now lies beyond the count.
		issue(OP_READ, 16'h1234, 16'h5678, 16'h9ABC, 8'd1);
		issue(OP_LOAD, 16'h00FF, 16'h0001, 16'h0000, 8'h55);
		issue(OP_READ, 16'hAAAA, 16'h5555, 16'hFFFF, 8'd0);
		clear_palette();
		issue(OP_LOAD, 16'h0100, 16'hFF00, 16'h0000, 8'hAA);
		issue(OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'd0);
		issue(OP_LOAD, 16'hAAAA, 16'h5555, 16'h0000, 8'h0F);
		issue(OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'd1);
		issue(OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'd0);
		issue(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
		issue(OP_READ, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd1);
	endtask

	task automatic run_phase(int budget, bit fill);
		int      sent, n, m, kind;
		flavor_t fl;
		sent = 0;
		if (fill) begin
			tx_calm = 1'b0;
			clear_palette();
			// The last four loads hit a full palette and are dropped.
			repeat (MAX_ENTRIES + 4) load_entry(FL_ANY);
			issue(OP_READ, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom), 8'd255);
			issue(OP_READ, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom), 8'd0);
			sent = MAX_ENTRIES + 7;
		end
		while (sent < budget) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				if ($urandom_range(0, 9) < 7) begin
					clear_palette();
					sent++;
				end
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				m = $urandom_range(1, 8);
				fl = flavor_t'($urandom_range(0, FL_ANY));
				repeat (n) load_entry(fl);
				repeat (m) read_one();
				sent += n + m;
			end else if (kind < 8) begin
				m = $urandom_range(2, 10);
				repeat (m) read_one();
				sent += m;
			end else begin
				m = $urandom_range(3, 10);
				repeat (m) noise_item();
				sent += m;
			end
			if ($urandom_range(0, 9) == 0) begin
				quiet_in();
				wait_drained();
			end
		end
	endtask

	// Receiver: ready with random stalls, switching between calm and stalling stretches.
	initial begin
		int hold;
		int span;
		hold = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				rx_calm = ($urandom_range(0, 2) == 0);
				span = $urandom_range(50, 250);
			end
			span--;
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 19))
						0:       hold = $urandom_range(30, 80);
						1, 2, 3: hold = $urandom_range(4, 10);
						default: hold = $urandom_range(1, 3);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		read_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.idx = entry_index;
			got.red = red_out;
			got.green = green_out;
			got.blue = blue_out;
			got.alpha = alpha_out;
			got.mult = multiplier;
			got.vld = entry_valid;
			sb.check_read(got);
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("run stopped after %0d cycles", LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (int p = 1; p <= 8; p++) begin
			settle();
			program_phase(p);
			run_phase((p == 1) ? 330 : 45, p == 1);
		end
		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== tiff_colormap_rescaler.f =====
+incdir+sv
sv/tcr_pkg.sv
sv/tcr_ram.sv
sv/tcr_divider.sv
sv/tiff_colormap_rescaler.sv
dv/tb.sv
